FILE: rtl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length line decoder.
// No dependencies; used by every module of the block.
package pcxrle_pkg;

  localparam int unsigned DIM_W   = 16;
  localparam int unsigned COL_W   = 17;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] RUN_MARK = 8'hc0;
  localparam logic [RUN_W-1:0]  RUN_MASK = 6'h3f;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 16'd256;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 16'd256;
  localparam logic [DIM_W-1:0] LINE_STRIDE_RST  = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;  // input request accepted this cycle
    logic step;  // one run pixel processed this cycle
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a pixel this cycle
    logic starts_run;  // offered byte is a value byte with a non-zero run
    logic run_end;     // current run step is the final one
  } status_t;

endpackage

FILE: rtl/pcxrle_ctrl.sv
// Controller for the PCX run-length line decoder: idle/run state machine.
// Depends on pcxrle_pkg.
module pcxrle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  pcxrle_pkg::status_t  status,
  output logic                 in_stall,
  output pcxrle_pkg::cmd_t     cmd
);

  pcxrle_pkg::state_t state, state_next;

  always_comb begin
    in_stall = !((state == pcxrle_pkg::ST_IDLE) && status.out_free);
    cmd.take = (state == pcxrle_pkg::ST_IDLE) && status.out_free && in_valid;
    cmd.step = (state == pcxrle_pkg::ST_RUN) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcxrle_pkg::ST_IDLE: begin
        if (cmd.take && status.starts_run) state_next = pcxrle_pkg::ST_RUN;
      end
      pcxrle_pkg::ST_RUN: begin
        if (cmd.step && status.run_end) state_next = pcxrle_pkg::ST_IDLE;
      end
      default: state_next = pcxrle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcxrle_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input is never taken while a run is being expanded
  a_no_take_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == pcxrle_pkg::ST_RUN) |-> !cmd.take)
    else $error("input taken during run");

  // a run that does not end keeps the machine in run
  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == pcxrle_pkg::ST_RUN) && !(cmd.step && status.run_end))
      |=> (state == pcxrle_pkg::ST_RUN))
    else $error("run left early");

  // a value byte starting a run always enters run
  a_run_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.starts_run) |=> (state == pcxrle_pkg::ST_RUN))
    else $error("run not started");

endmodule

FILE: rtl/pcxrle_datapath.sv
// Datapath for the PCX run-length line decoder: registers, counters,
// pixel position logic and output register. Depends on pcxrle_pkg.
module pcxrle_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  pcxrle_pkg::cmd_t     cmd,
  output pcxrle_pkg::status_t  status,
  input  logic [7:0]           data_byte,
  input  logic                 first,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           pixel,
  output logic [15:0]          column,
  output logic [15:0]          row,
  output logic                 last
);

  logic [15:0] image_width, image_height, line_stride;
  logic        await_value;
  logic [5:0]  run_length;
  logic [16:0] column_count;
  logic [15:0] row_count;
  logic        image_done;
  logic [7:0]  run_value;
  logic [5:0]  remaining;

  // state as seen by the offered byte, after an optional clear
  logic        eff_await, eff_done;
  logic [5:0]  eff_run;
  logic [16:0] col_sel, col_inc, col_next;
  logic [15:0] row_sel, row_inc, row_next;
  logic        is_mark, pix_emit, line_end, done_set, last_run;
  logic        lit_take, pix_load;

  always_comb begin
    eff_await = first ? 1'b0 : await_value;
    eff_done  = first ? 1'b0 : image_done;
    eff_run   = first ? 6'd0 : run_length;
    col_sel   = cmd.step ? column_count : (first ? 17'd0 : column_count);
    row_sel   = cmd.step ? row_count : (first ? 16'd0 : row_count);
    is_mark   = (data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;

    pix_emit  = col_sel < {1'b0, image_width};
    col_inc   = col_sel + 17'd1;
    line_end  = col_inc >= {1'b0, line_stride};
    row_inc   = row_sel + 16'd1;
    done_set  = line_end && ((row_inc >= image_height) || (row_inc == 16'd0));
    col_next  = line_end ? 17'd0 : col_inc;
    row_next  = line_end ? row_inc : row_sel;
    // emitted pixels of a run form a prefix, so the next one is dropped once
    // the column reaches the width
    last_run  = (remaining == 6'd1) || line_end || (col_inc >= {1'b0, image_width});

    lit_take  = cmd.take && !eff_done && !eff_await && !is_mark;
    pix_load  = (lit_take || cmd.step) && pix_emit;

    status.out_free   = !out_valid || !out_stall;
    status.starts_run = !eff_done && eff_await && (eff_run != 6'd0);
    status.run_end    = (remaining == 6'd1) || line_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pcxrle_pkg::IMAGE_WIDTH_RST;
      image_height <= pcxrle_pkg::IMAGE_HEIGHT_RST;
      line_stride  <= pcxrle_pkg::LINE_STRIDE_RST;
      await_value  <= 1'b0;
      run_length   <= 6'd0;
      column_count <= 17'd0;
      row_count    <= 16'd0;
      image_done   <= 1'b0;
      remaining    <= 6'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pcxrle_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          pcxrle_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          pcxrle_pkg::REG_LINE_STRIDE:  line_stride  <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.take) begin
        if (first) begin
          await_value  <= 1'b0;
          run_length   <= 6'd0;
          column_count <= 17'd0;
          row_count    <= 16'd0;
          image_done   <= 1'b0;
        end
        if (!eff_done) begin
          if (eff_await) begin
            await_value <= 1'b0;
            run_length  <= 6'd0;
            remaining   <= eff_run;
          end else if (is_mark) begin
            await_value <= 1'b1;
            run_length  <= data_byte[5:0] & pcxrle_pkg::RUN_MASK;
          end else begin
            column_count <= col_next;
            row_count    <= row_next;
            image_done   <= done_set;
          end
        end
      end else if (cmd.step) begin
        column_count <= col_next;
        row_count    <= row_next;
        image_done   <= done_set;
        remaining    <= remaining - 6'd1;
      end

      if (pix_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.take && eff_await) begin
      run_value <= data_byte;
    end
    if (pix_load) begin
      pixel  <= cmd.step ? run_value : data_byte;
      column <= col_sel[15:0];
      row    <= row_sel;
      last   <= cmd.step ? last_run : 1'b1;
    end
  end

  a_step_has_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (remaining != 6'd0))
    else $error("run step with empty count");

  a_take_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && cmd.step))
    else $error("take and step together");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && image_done && !first) |-> !pix_load)
    else $error("pixel after image end");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    pix_load |-> status.out_free)
    else $error("output overwritten");

endmodule

FILE: rtl/pcx_rle_line_decoder_top.sv
// PCX run-length line decoder, top level: ties controller and datapath.
// Depends on pcxrle_pkg, pcxrle_ctrl and pcxrle_datapath.
//
// Decodes the pixel data of an 8-bit PCX image, one encoded byte per
// request, starting after the 128-byte header. A byte with both top bits set
// holds a run count of 0 to 63 and the byte after it is the value to repeat;
// any other byte is one literal pixel. Pixels are delivered with their column
// and row, only while the column is below image_width; a line ends when the
// column reaches line_stride, so padding and the rest of an overrunning run
// are dropped. After image_height lines further bytes give nothing until a
// request with first set, which clears the counters before its byte is
// decoded. 'last' marks the final pixel caused by one input byte.
// Timing: literal and run count bytes are taken at one per cycle while the
// output is free. A value byte is taken and then expanded by the run state
// of the controller at one pixel position per cycle while the output is
// free, N positions for a run of N (dropped positions included, fewer if
// the line ends first); input is stalled meanwhile. Output stall holds both
// the pixel register and, through it, the input side.
// Configuration (index 0 image_width, 1 image_height, 2 line_stride; reset
// value 256 each) is always ready and is to be written only while idle.
module pcx_rle_line_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first,
  // decoded pixels
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel,
  output logic [15:0] column,
  output logic [15:0] row,
  output logic        last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  pcxrle_pkg::cmd_t    cmd;
  pcxrle_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pcxrle_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .data_byte (data_byte),
    .first     (first),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel),
    .column    (column),
    .row       (row),
    .last      (last)
  );

endmodule
